>>> src/perspective_projection_unit_macros.svh
// assertion macros used by the perspective projection unit top level
// no dependencies; included by the top-level module, which carries concurrent checks
`ifndef PERSPECTIVE_PROJECTION_UNIT_MACROS_SVH
`define PERSPECTIVE_PROJECTION_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define PPU_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ppu check failed");

// next-cycle implication, disabled during reset
`define PPU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ppu check failed");

`endif

>>> src/ppu_pkg.sv
// shared constants, types and helpers of the perspective projection unit
// no dependencies
package ppu_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int DIV_W      = 32 + FRAC_BITS;
    localparam int Q_W        = 42;
    localparam int SIZE_W     = 14;
    localparam int THR_W      = 31;
    localparam int NUM_COEFS  = 12;
    localparam int COEF_IDX_W = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int NUM_PROD   = 9;

    localparam logic [63:0] Q_LIMIT = 64'd1 << 40;

    localparam logic [SIZE_W-1:0] WIDTH_RST  = SIZE_W'(1920);
    localparam logic [SIZE_W-1:0] HEIGHT_RST = SIZE_W'(1080);
    localparam logic [THR_W-1:0]  NEAR_RST   =
        THR_W'((64'd65 * (64'd1 << FRAC_BITS) + 64'd50) / 64'd100);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_NEAR   = 2'd2,
        CFG_NONE   = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        REQ_LOAD  = 1'b0,
        REQ_POINT = 1'b1
    } t_req;

    // side data that rides along the divider
    typedef struct packed {
        logic        on;
        logic        sign_x;
        logic        sign_y;
        logic [31:0] cw;
    } t_div_tag;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

>>> src/ppu_dot.sv
// clip space transform: nine products, then three dot sums with saturation
// depends on ppu_pkg
module ppu_dot
    import ppu_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic signed [31:0] i_x,
    input  logic signed [31:0] i_y,
    input  logic signed [31:0] i_z,
    input  logic signed [31:0] i_coef [NUM_COEFS],
    input  logic [THR_W-1:0]   i_thr,
    output logic               o_valid,
    output logic               o_on,
    output logic signed [31:0] o_cx,
    output logic signed [31:0] o_cy,
    output logic signed [31:0] o_cw
);

    logic               r_v1;
    logic signed [63:0] r_prod [NUM_PROD];
    logic signed [31:0] r_const [3];
    logic signed [31:0] n_clip [3];
    logic [THR_W-1:0]   n_thr;
    logic               r_v2;
    logic               r_on;
    logic signed [31:0] r_clip [3];

    // stage 1: products, constant terms captured with them
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r_prod[c*3]     <= i_coef[c*4]     * i_x;
                r_prod[c*3 + 1] <= i_coef[c*4 + 1] * i_y;
                r_prod[c*3 + 2] <= i_coef[c*4 + 2] * i_z;
                r_const[c]      <= i_coef[c*4 + 3];
            end
        end
    end

    // stage 2: floored sums and near test
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_clip[c] = sat32((r_prod[c*3] >>> FRAC_BITS)
                            + (r_prod[c*3 + 1] >>> FRAC_BITS)
                            + (r_prod[c*3 + 2] >>> FRAC_BITS)
                            + 64'(r_const[c]));
        end
        n_thr = (i_thr == '0) ? THR_W'(1) : i_thr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_clip <= n_clip;
            r_on   <= (n_clip[2] >= $signed({1'b0, n_thr}));
        end
    end

    assign o_valid = r_v2;
    assign o_on    = r_on;
    assign o_cx    = r_clip[0];
    assign o_cy    = r_clip[1];
    assign o_cw    = r_clip[2];

endmodule

>>> src/ppu_divider.sv
// two-lane pipelined restoring divider, one quotient bit per stage
// shares the divisor clip w; depends on ppu_pkg
module ppu_divider
    import ppu_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic                  i_on,
    input  logic signed [31:0]    i_cx,
    input  logic signed [31:0]    i_cy,
    input  logic signed [31:0]    i_cw,
    output logic                  o_valid,
    output t_div_tag              o_tag,
    output logic signed [Q_W-1:0] o_qx,
    output logic signed [Q_W-1:0] o_qy
);

    logic             r_v   [DIV_W+1];
    t_div_tag         r_tag [DIV_W+1];
    logic [30:0]      r_rx  [DIV_W+1];
    logic [30:0]      r_ry  [DIV_W+1];
    logic [DIV_W-1:0] r_nx  [DIV_W+1];
    logic [DIV_W-1:0] r_ny  [DIV_W+1];

    logic [32:0] n_negx;
    logic [32:0] n_negy;
    logic [31:0] n_magx;
    logic [31:0] n_magy;
    t_div_tag    n_tag;

    logic                  r_vo;
    t_div_tag              r_tago;
    logic signed [Q_W-1:0] r_qx;
    logic signed [Q_W-1:0] r_qy;

    // entry: magnitudes scaled by the fraction
    always_comb begin
        n_negx     = -{i_cx[31], i_cx};
        n_negy     = -{i_cy[31], i_cy};
        n_magx     = i_cx[31] ? n_negx[31:0] : i_cx;
        n_magy     = i_cy[31] ? n_negy[31:0] : i_cy;
        n_tag.on     = i_on;
        n_tag.sign_x = i_cx[31];
        n_tag.sign_y = i_cy[31];
        n_tag.cw     = i_cw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag[0] <= n_tag;
            r_rx[0]  <= '0;
            r_ry[0]  <= '0;
            r_nx[0]  <= {n_magx, FRAC_BITS'(0)};
            r_ny[0]  <= {n_magy, FRAC_BITS'(0)};
        end
    end

    // one restoring step per stage
    for (genvar s = 0; s < DIV_W; s++) begin : g_step
        logic [31:0] n_tx;
        logic [31:0] n_ty;
        logic [31:0] n_w;
        logic        n_bx;
        logic        n_by;
        logic [31:0] n_dx;
        logic [31:0] n_dy;

        always_comb begin
            n_w  = {1'b0, r_tag[s].cw[30:0]};
            n_tx = {r_rx[s], r_nx[s][DIV_W-1]};
            n_ty = {r_ry[s], r_ny[s][DIV_W-1]};
            n_bx = (n_tx >= n_w);
            n_by = (n_ty >= n_w);
            n_dx = n_bx ? (n_tx - n_w) : n_tx;
            n_dy = n_by ? (n_ty - n_w) : n_ty;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else if (i_en) begin
                r_v[s+1] <= r_v[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tag[s+1] <= r_tag[s];
                r_rx[s+1]  <= n_dx[30:0];
                r_ry[s+1]  <= n_dy[30:0];
                r_nx[s+1]  <= {r_nx[s][DIV_W-2:0], n_bx};
                r_ny[s+1]  <= {r_ny[s][DIV_W-2:0], n_by};
            end
        end
    end

    // exit: clamp magnitude, restore sign
    logic [63:0]           n_mx;
    logic [63:0]           n_my;
    logic signed [Q_W-1:0] n_qx;
    logic signed [Q_W-1:0] n_qy;

    always_comb begin
        n_mx = 64'(r_nx[DIV_W]);
        n_my = 64'(r_ny[DIV_W]);
        if (n_mx > Q_LIMIT) begin
            n_mx = Q_LIMIT;
        end
        if (n_my > Q_LIMIT) begin
            n_my = Q_LIMIT;
        end
        n_qx = r_tag[DIV_W].sign_x ? -$signed(n_mx[Q_W-1:0]) : $signed(n_mx[Q_W-1:0]);
        n_qy = r_tag[DIV_W].sign_y ? -$signed(n_my[Q_W-1:0]) : $signed(n_my[Q_W-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (i_en) begin
            r_vo <= r_v[DIV_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tago <= r_tag[DIV_W];
            r_qx   <= n_qx;
            r_qy   <= n_qy;
        end
    end

    assign o_valid = r_vo;
    assign o_tag   = r_tago;
    assign o_qx    = r_qx;
    assign o_qy    = r_qy;

endmodule

>>> src/ppu_scale.sv
// viewport scaling: size times ratio, halved, offset from the screen center
// depends on ppu_pkg
module ppu_scale
    import ppu_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  t_div_tag              i_tag,
    input  logic signed [Q_W-1:0] i_qx,
    input  logic signed [Q_W-1:0] i_qy,
    input  logic [SIZE_W-1:0]     i_width,
    input  logic [SIZE_W-1:0]     i_height,
    output logic                  o_valid,
    output logic                  o_on,
    output logic signed [31:0]    o_sx,
    output logic signed [31:0]    o_sy,
    output logic signed [31:0]    o_w
);

    localparam int P_W = SIZE_W + 1 + Q_W;

    logic                  r_v1;
    t_div_tag              r_tag;
    logic signed [P_W-1:0] r_px;
    logic signed [P_W-1:0] r_py;

    logic signed [63:0] n_tx;
    logic signed [63:0] n_ty;
    logic signed [63:0] n_cx;
    logic signed [63:0] n_cy;

    logic               r_v2;
    logic               r_on;
    logic signed [31:0] r_sx;
    logic signed [31:0] r_sy;
    logic signed [31:0] r_w;

    // stage 1: size times ratio
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag <= i_tag;
            r_px  <= $signed({1'b0, i_width}) * i_qx;
            r_py  <= $signed({1'b0, i_height}) * i_qy;
        end
    end

    // stage 2: halve toward zero, offset from the center (x added, y subtracted), saturate; zero when off
    always_comb begin
        n_tx = $signed(64'(r_px) + 64'(r_px[P_W-1])) >>> 1;
        n_ty = $signed(64'(r_py) + 64'(r_py[P_W-1])) >>> 1;
        n_cx = $signed(64'(i_width) << (FRAC_BITS - 1));
        n_cy = $signed(64'(i_height) << (FRAC_BITS - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_on <= r_tag.on;
            r_w  <= r_tag.cw;
            r_sx <= r_tag.on ? sat32(n_cx + n_tx) : 32'sd0;
            r_sy <= r_tag.on ? sat32(n_cy - n_ty) : 32'sd0;
        end
    end

    assign o_valid = r_v2;
    assign o_on    = r_on;
    assign o_sx    = r_sx;
    assign o_sy    = r_sy;
    assign o_w     = r_w;

endmodule

>>> src/perspective_projection_unit.sv
// an accepted point beat runs through the divider, one quotient bit per stage, and six further
// arithmetic stages before its Q16.16 result appears
// throughput: one beat per cycle while the output register is empty or taken; a load beat gives no result
// the whole pipeline advances together while the output register is empty or taken
// reset (synchronous, active low) clears valid bits and loads the default screen settings;
// the coefficient store is not cleared
`include "perspective_projection_unit_macros.svh"

module perspective_projection_unit
    import ppu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // coef_index[3:0], coef_value[35:4], world_x[67:36], world_y[99:68],
    // world_z[131:100], zero pad[135:132]
    input  logic [135:0]         s_axis_tdata,
    // req_type[0]
    input  logic [0:0]           s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // screen_x[31:0], screen_y[63:32], depth_w[95:64]
    output logic [95:0]          m_axis_tdata,
    // on_screen[0]
    output logic [0:0]           m_axis_tuser,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [THR_W-1:0]     i_cfg_data
);

    logic [SIZE_W-1:0]  r_width;
    logic [SIZE_W-1:0]  r_height;
    logic [THR_W-1:0]   r_near;
    logic signed [31:0] r_coef [NUM_COEFS];

    logic                    n_en;
    logic                    n_acc;
    logic [COEF_IDX_W-1:0]   n_idx;
    logic                    n_load;
    logic                    d_valid;
    logic                    d_on;
    logic signed [31:0]      d_cx;
    logic signed [31:0]      d_cy;
    logic signed [31:0]      d_cw;
    logic                    q_valid;
    t_div_tag                q_tag;
    logic signed [Q_W-1:0]   q_x;
    logic signed [Q_W-1:0]   q_y;
    logic                    s_on;
    logic signed [31:0]      s_x;
    logic signed [31:0]      s_y;
    logic signed [31:0]      s_w;
    logic [THR_W-1:0]        n_thr;
    logic                    n_off_beat;
    logic                    n_on_beat;
    logic                    n_out_stall;
    logic                    n_depth_ok;

    // global advance: output register empty or being drained
    assign n_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = n_en;
    assign n_acc         = s_axis_tvalid && s_axis_tready;
    assign n_idx         = s_axis_tdata[COEF_IDX_W-1:0];
    assign n_load        = n_acc && (t_req'(s_axis_tuser[0]) == REQ_LOAD);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
            r_near   <= NEAR_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_WIDTH:  r_width  <= i_cfg_data[SIZE_W-1:0];
                CFG_HEIGHT: r_height <= i_cfg_data[SIZE_W-1:0];
                CFG_NEAR:   r_near   <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // coefficient store, written by load beats
    always_ff @(posedge i_clk) begin
        if (n_load && (n_idx < COEF_IDX_W'(NUM_COEFS))) begin
            r_coef[n_idx] <= $signed(s_axis_tdata[35:4]);
        end
    end

    ppu_dot u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_valid (n_acc && (t_req'(s_axis_tuser[0]) == REQ_POINT)),
        .i_x     ($signed(s_axis_tdata[67:36])),
        .i_y     ($signed(s_axis_tdata[99:68])),
        .i_z     ($signed(s_axis_tdata[131:100])),
        .i_coef  (r_coef),
        .i_thr   (r_near),
        .o_valid (d_valid),
        .o_on    (d_on),
        .o_cx    (d_cx),
        .o_cy    (d_cy),
        .o_cw    (d_cw)
    );

    ppu_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_valid (d_valid),
        .i_on    (d_on),
        .i_cx    (d_cx),
        .i_cy    (d_cy),
        .i_cw    (d_cw),
        .o_valid (q_valid),
        .o_tag   (q_tag),
        .o_qx    (q_x),
        .o_qy    (q_y)
    );

    ppu_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (n_en),
        .i_valid  (q_valid),
        .i_tag    (q_tag),
        .i_qx     (q_x),
        .i_qy     (q_y),
        .i_width  (r_width),
        .i_height (r_height),
        .o_valid  (m_axis_tvalid),
        .o_on     (s_on),
        .o_sx     (s_x),
        .o_sy     (s_y),
        .o_w      (s_w)
    );

    assign m_axis_tdata = {s_w, s_y, s_x};
    assign m_axis_tuser = s_on;

    // effective near threshold and beat conditions for checks
    assign n_thr       = (r_near == '0) ? THR_W'(1) : r_near;
    assign n_off_beat  = m_axis_tvalid && !m_axis_tuser[0];
    assign n_on_beat   = m_axis_tvalid && m_axis_tuser[0];
    assign n_out_stall = m_axis_tvalid && !m_axis_tready;
    assign n_depth_ok  = $signed(m_axis_tdata[95:64]) >= $signed({1'b0, n_thr});

    `PPU_ASSERT_NOW(a_off_zero, i_clk, i_rst_n, n_off_beat, m_axis_tdata[63:0] == 64'd0)
    `PPU_ASSERT_NOW(a_on_depth, i_clk, i_rst_n, n_on_beat, n_depth_ok)
    `PPU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, n_out_stall, m_axis_tvalid && $stable(m_axis_tdata))

endmodule
